@@ rtl/rpf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_pkg
// Types and constants shared by the radio packet framer modules.
// ----------------------------------------------------------------------------
package rpf_pkg;

	localparam logic [7:0]  FILL_BYTE  = 8'hAA;
	localparam logic [7:0]  CRC_POLY   = 8'h8C;
	localparam logic [15:0] SYNC_RESET = 16'h2DD4;
	localparam logic [7:0]  LEN_BIAS   = 8'h01;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_DATA  = 1'b1
	} cmd_kind_t;

	// one classified word handed from front to back
	typedef struct packed {
		cmd_kind_t  kind;
		logic       close;
		logic [7:0] value;
		logic [7:0] crc;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_NEW,
		PH_PRE,
		PH_SYNC_HI,
		PH_SYNC_LO,
		PH_LEN,
		PH_DATA,
		PH_CRC,
		PH_TRAIL
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/rpf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_front
// Accepts input words, tracks the open frame and the running crc, and
// pushes one classified command per word that produces output.
// ----------------------------------------------------------------------------
module rpf_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         op,
	input  wire logic [7:0]   payload_length,
	input  wire logic [7:0]   data_byte,
	input  wire logic         q_full,
	output logic              push,
	output rpf_pkg::cmd_t     push_cmd
);
	import rpf_pkg::*;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic       frame_open_q;
	logic [7:0] bytes_left_q;
	logic [7:0] crc_q;

	logic       accept;
	logic       is_start;
	logic [7:0] len_byte;
	logic [7:0] crc_next;
	logic       last_data;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign is_start  = (op_t'(op) == OP_START);
	assign len_byte  = payload_length + LEN_BIAS;
	assign crc_next  = is_start ? crc_step(8'h00, len_byte) : crc_step(crc_q, data_byte);
	assign last_data = (bytes_left_q == 8'd1);

	assign push = accept && (is_start || frame_open_q);

	always_comb begin
		push_cmd.kind  = is_start ? CMD_START : CMD_DATA;
		push_cmd.close = is_start ? (payload_length == 8'd0) : last_data;
		push_cmd.value = is_start ? len_byte : data_byte;
		push_cmd.crc   = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'd0;
			crc_q        <= 8'd0;
		end else if (push) begin
			crc_q <= crc_next;
			if (is_start) begin
				frame_open_q <= (payload_length != 8'd0);
				bytes_left_q <= payload_length;
			end else begin
				frame_open_q <= !last_data;
				bytes_left_q <= bytes_left_q - 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/rpf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rpf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rpf_pkg::cmd_t push_cmd,
	output logic               full,
	output logic               head_valid,
	output rpf_pkg::cmd_t      head_cmd,
	input  wire logic          pop
);
	import rpf_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/rpf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rpf_back
// Expands each queued command into frame bytes and drives the output
// register, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rpf_back #(
	parameter int PREAMBLE_COUNT = 3,
	parameter int TRAILER_COUNT  = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [15:0]   sync_word,
	input  wire logic          head_valid,
	input  wire rpf_pkg::cmd_t head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               frame_end
);
	import rpf_pkg::*;

	localparam int MAX_COUNT = (PREAMBLE_COUNT > TRAILER_COUNT) ? PREAMBLE_COUNT
	                                                            : TRAILER_COUNT;
	localparam int CNT_W     = $clog2(MAX_COUNT) + 1;

	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;

	phase_t           cur_phase;
	logic [CNT_W-1:0] cur_cnt;
	phase_t           phase_d;
	logic [CNT_W-1:0] cnt_d;
	logic             load_ok;
	logic             emit;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic             cmd_done;

	assign load_ok = !out_valid_q || !out_stall;
	assign emit    = head_valid && load_ok;
	assign pop     = emit && cmd_done;

	always_comb begin
		if (phase_q == PH_NEW) begin
			cur_phase = (head_cmd.kind == CMD_START) ? PH_PRE : PH_DATA;
			cur_cnt   = '0;
		end else begin
			cur_phase = phase_q;
			cur_cnt   = cnt_q;
		end
	end

	// byte selection per phase
	always_comb begin
		emit_byte = FILL_BYTE;
		emit_last = 1'b0;
		cmd_done  = 1'b0;
		unique case (cur_phase)
			PH_PRE: begin
				emit_byte = FILL_BYTE;
			end
			PH_SYNC_HI: begin
				emit_byte = sync_word[15:8];
			end
			PH_SYNC_LO: begin
				emit_byte = sync_word[7:0];
			end
			PH_LEN, PH_DATA: begin
				emit_byte = head_cmd.value;
				cmd_done  = !head_cmd.close;
			end
			PH_CRC: begin
				emit_byte = head_cmd.crc;
				emit_last = (TRAILER_COUNT == 0);
				cmd_done  = (TRAILER_COUNT == 0);
			end
			PH_TRAIL: begin
				emit_byte = FILL_BYTE;
				emit_last = (cur_cnt == CNT_W'(TRAILER_COUNT - 1));
				cmd_done  = emit_last;
			end
			default: begin
				emit_byte = FILL_BYTE;
			end
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		if (emit) begin
			if (cmd_done) begin
				phase_d = PH_NEW;
				cnt_d   = '0;
			end else begin
				unique case (cur_phase)
					PH_PRE: begin
						if (cur_cnt == CNT_W'(PREAMBLE_COUNT - 1)) begin
							phase_d = PH_SYNC_HI;
							cnt_d   = '0;
						end else begin
							phase_d = PH_PRE;
							cnt_d   = cur_cnt + 1'b1;
						end
					end
					PH_SYNC_HI: phase_d = PH_SYNC_LO;
					PH_SYNC_LO: phase_d = PH_LEN;
					PH_LEN, PH_DATA: begin
						phase_d = PH_CRC;
						cnt_d   = '0;
					end
					PH_CRC: begin
						phase_d = PH_TRAIL;
						cnt_d   = '0;
					end
					PH_TRAIL: begin
						phase_d = PH_TRAIL;
						cnt_d   = cur_cnt + 1'b1;
					end
					default: phase_d = PH_NEW;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NEW;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			if (load_ok) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= emit_byte;
			frame_end_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

endmodule
`default_nettype wire

@@ rtl/radio_packet_framer_crc8_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// radio_packet_framer_crc8_top
// Radio frame builder: preamble, sync, length, payload, crc-8, trailer.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------
//   input   | in        | in_valid / in_stall  | op, payload_length, data_byte
//   output  | out       | out_valid / out_stall| out_byte, frame_end
//   config  | in        | cfg_wr_en            | cfg_wr_data (sync word)
//
// an input word is taken every cycle while the 4-entry command queue has room
// the back emits one byte per cycle unless stalled; a payload word is one byte,
// a start word PREAMBLE_COUNT + 3 bytes, a closing word TRAILER_COUNT + 1 more
// an input word passes through the queue and then the output register
// output stall holds the output register and, once the queue fills, the input
// reset is asynchronous; the sync word resets to 16'h2DD4
// ----------------------------------------------------------------------------
module radio_packet_framer_crc8_top #(
	parameter int PREAMBLE_COUNT = 3,
	parameter int TRAILER_COUNT  = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  payload_length,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             frame_end
);
	import rpf_pkg::*;

	logic [15:0] sync_word_q;
	logic        q_full;
	logic        push;
	cmd_t        push_cmd;
	logic        head_valid;
	cmd_t        head_cmd;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_word_q <= cfg_wr_data;
		end
	end

	rpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.q_full         (q_full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	rpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	rpf_back #(
		.PREAMBLE_COUNT (PREAMBLE_COUNT),
		.TRAILER_COUNT  (TRAILER_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_word  (sync_word_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full queue");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_end_is_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end && (TRAILER_COUNT != 0)) |-> (out_byte == FILL_BYTE))
		else $error("frame end on a non-trailer byte");

endmodule
`default_nettype wire
